### rtl/core/lmrs_pkg.sv
// Package for the LED matrix row scan driver.
// Holds the shared types, register indexes, result kinds and a helper function.
// No dependencies.
package lmrs_pkg;

  localparam int unsigned RowBits  = 5;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgTwoPortMode     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSixBitColor     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRowMask         = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIntervalPhase0  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgIntervalPhase1  = 3'd4;

  localparam logic KindShift = 1'b0;
  localparam logic KindLatch = 1'b1;

  typedef struct packed {
    logic                 two_port_mode;
    logic                 six_bit_color;
    logic [AddrW-1:0]     row_mask;
    logic [15:0]          interval_phase_zero;
    logic [15:0]          interval_phase_one;
  } cfg_t;

  typedef struct packed {
    logic [7:0] upper_color;
    logic [7:0] lower_color;
    logic       row_end;
  } pixel_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       port_a_data;
    logic [7:0]       port_b_data;
    logic [AddrW-1:0] row_address;
    logic [15:0]      next_interval;
    logic             last;
  } result_t;

  function automatic logic [7:0] nibble_swap(logic [7:0] v);
    return {v[3:0], v[7:4]};
  endfunction

endpackage

### rtl/core/lmrs_pixel_if.sv
// Pixel pair channel of the LED matrix row scan driver.
// Carries valid, ready and one pixel pair per transaction. No dependencies.
interface lmrs_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] upper_color;
  logic [7:0] lower_color;
  logic       row_end;

  modport source (output valid, output upper_color, output lower_color, output row_end,
                  input ready);
  modport sink (input valid, input upper_color, input lower_color, input row_end,
                output ready);
endinterface

### rtl/core/lmrs_result_if.sv
// Result channel of the LED matrix row scan driver.
// Carries valid, ready and one shift or latch result per transaction. No dependencies.
interface lmrs_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  port_a_data;
  logic [7:0]  port_b_data;
  logic [4:0]  row_address;
  logic [15:0] next_interval;
  logic        last;

  modport source (output valid, output kind, output port_a_data, output port_b_data,
                  output row_address, output next_interval, output last, input ready);
  modport sink (input valid, input kind, input port_a_data, input port_b_data,
                input row_address, input next_interval, input last, output ready);
endinterface

### rtl/core/led_matrix_row_scan_driver.sv
// Each accepted pixel pair passes the input register and the result register and gives one
// shift result; a pair marked as row end adds a latch result right behind it, with the row
// address and the next refresh interval. Plain pairs stream at one per cycle while the sink
// takes every result; a row-end pair holds the two-entry result register until both are taken.
// The input register, when empty, accepts a new pair while a result still waits downstream.
// Users must write configuration only while the block is idle; no logic here enforces it.
// Top level; depends on lmrs_pkg, lmrs_pixel_if, lmrs_result_if, lmrs_cfg_regs,
// lmrs_scan_core and lmrs_result_buf.
module led_matrix_row_scan_driver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lmrs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lmrs_pkg::CfgDataW-1:0] cfg_data_i,
  lmrs_pixel_if.sink                    pixel_i,
  lmrs_result_if.source                 result_o
);

  lmrs_pkg::cfg_t    cfg;
  lmrs_pkg::pixel_t  pix_q;
  lmrs_pkg::result_t shift_res, latch_res, head;
  logic              in_v_q, in_v_d;
  logic              accept, move, buf_free;

  assign move           = in_v_q && buf_free;
  assign pixel_i.ready  = !in_v_q || buf_free;
  assign accept         = pixel_i.valid && pixel_i.ready;

  always_comb begin
    in_v_d = in_v_q;
    if (accept) begin
      in_v_d = 1'b1;
    end else if (move) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q.upper_color <= pixel_i.upper_color;
      pix_q.lower_color <= pixel_i.lower_color;
      pix_q.row_end     <= pixel_i.row_end;
    end
  end

  lmrs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lmrs_scan_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .pixel_i   (pix_q),
    .advance_i (move),
    .shift_o   (shift_res),
    .latch_o   (latch_res)
  );

  lmrs_result_buf u_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (move),
    .shift_i    (shift_res),
    .latch_i    (latch_res),
    .latch_en_i (pix_q.row_end),
    .free_o     (buf_free),
    .valid_o    (result_o.valid),
    .ready_i    (result_o.ready),
    .data_o     (head)
  );

  assign result_o.kind          = head.kind;
  assign result_o.port_a_data   = head.port_a_data;
  assign result_o.port_b_data   = head.port_b_data;
  assign result_o.row_address   = head.row_address;
  assign result_o.next_interval = head.next_interval;
  assign result_o.last          = head.last;

  a_latch_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.kind == lmrs_pkg::KindLatch) |-> result_o.last)
    else $error("latch result without last");

  a_move_shows_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> result_o.valid && (result_o.kind == lmrs_pkg::KindShift))
    else $error("loaded pair does not present its shift result first");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !buf_free |=> in_v_q)
    else $error("input stage dropped a pair while the result register was full");

endmodule

### rtl/core/lmrs_cfg_regs.sv
// Configuration registers of the LED matrix row scan driver.
// Depends on lmrs_pkg.
module lmrs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lmrs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lmrs_pkg::CfgDataW-1:0] cfg_data_i,
  output lmrs_pkg::cfg_t                cfg_o
);

  lmrs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lmrs_pkg::CfgTwoPortMode:    cfg_d.two_port_mode       = cfg_data_i[0];
        lmrs_pkg::CfgSixBitColor:    cfg_d.six_bit_color       = cfg_data_i[0];
        lmrs_pkg::CfgRowMask:        cfg_d.row_mask            = cfg_data_i[4:0];
        lmrs_pkg::CfgIntervalPhase0: cfg_d.interval_phase_zero = cfg_data_i[15:0];
        lmrs_pkg::CfgIntervalPhase1: cfg_d.interval_phase_one  = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.two_port_mode       <= 1'b0;
      cfg_q.six_bit_color       <= 1'b0;
      cfg_q.row_mask            <= 5'd15;
      cfg_q.interval_phase_zero <= 16'd32;
      cfg_q.interval_phase_one  <= 16'd64;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/lmrs_scan_core.sv
// Scan logic of the LED matrix row scan driver: port data, row counter, color phase.
// Depends on lmrs_pkg.
module lmrs_scan_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lmrs_pkg::cfg_t   cfg_i,
  input  lmrs_pkg::pixel_t pixel_i,
  input  logic             advance_i,
  output lmrs_pkg::result_t shift_o,
  output lmrs_pkg::result_t latch_o
);

  logic [lmrs_pkg::RowBits-1:0] row_cnt_q, row_cnt_d;
  logic                         phase_q, phase_d;
  logic [7:0]                   pa, pb;

  always_comb begin
    if (cfg_i.two_port_mode) begin
      pa = phase_q ? lmrs_pkg::nibble_swap(pixel_i.lower_color) : pixel_i.lower_color;
      pb = phase_q ? lmrs_pkg::nibble_swap(pixel_i.upper_color) : pixel_i.upper_color;
    end else begin
      pa = {pixel_i.upper_color[2:0], 5'b0} | {pixel_i.lower_color[5:0], 2'b0};
      pb = 8'd0;
    end
  end

  always_comb begin
    row_cnt_d = (row_cnt_q + lmrs_pkg::RowBits'(1))
                & lmrs_pkg::RowBits'(cfg_i.row_mask);
    phase_d   = phase_q ^ ((row_cnt_d == '0) && cfg_i.six_bit_color);
  end

  always_comb begin
    shift_o.kind          = lmrs_pkg::KindShift;
    shift_o.port_a_data   = pa;
    shift_o.port_b_data   = pb;
    shift_o.row_address   = '0;
    shift_o.next_interval = '0;
    shift_o.last          = !pixel_i.row_end;

    latch_o.kind          = lmrs_pkg::KindLatch;
    latch_o.port_a_data   = '0;
    latch_o.port_b_data   = '0;
    latch_o.row_address   = lmrs_pkg::AddrW'(row_cnt_q);
    latch_o.next_interval = phase_d ? cfg_i.interval_phase_one : cfg_i.interval_phase_zero;
    latch_o.last          = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      phase_q   <= 1'b0;
    end else if (advance_i && pixel_i.row_end) begin
      row_cnt_q <= row_cnt_d;
      phase_q   <= phase_d;
    end
  end

endmodule

### rtl/core/lmrs_result_buf.sv
// Two-entry result register of the LED matrix row scan driver.
// Holds the shift result and the optional latch result of one pair. Depends on lmrs_pkg.
module lmrs_result_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lmrs_pkg::result_t shift_i,
  input  lmrs_pkg::result_t latch_i,
  input  logic              latch_en_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output lmrs_pkg::result_t data_o
);

  lmrs_pkg::result_t shift_q, latch_q;
  logic              shift_v_q, latch_v_q;
  logic              pop;

  assign valid_o = shift_v_q || latch_v_q;
  assign pop     = valid_o && ready_i;
  assign data_o  = shift_v_q ? shift_q : latch_q;
  assign free_o  = !valid_o || (pop && (shift_v_q ^ latch_v_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_v_q <= 1'b0;
      latch_v_q <= 1'b0;
    end else if (load_i) begin
      shift_v_q <= 1'b1;
      latch_v_q <= latch_en_i;
    end else if (pop) begin
      if (shift_v_q) begin
        shift_v_q <= 1'b0;
      end else begin
        latch_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      shift_q <= shift_i;
      latch_q <= latch_i;
    end
  end

endmodule

### test/tb_led_matrix_row_scan_driver.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LED matrix row scan driver: pixel pairs go in, shift and
// latch transactions are predicted and compared field by field in order.
// Depends on lmrs_pkg, lmrs_pixel_if, lmrs_result_if and led_matrix_row_scan_driver.
module tb_led_matrix_row_scan_driver;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned RandPhases  = 14;
  localparam int unsigned PhasePairs  = 122;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [lmrs_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [lmrs_pkg::CfgDataW-1:0] cfg_data_i;

  lmrs_pixel_if  pix_if ();
  lmrs_result_if res_if ();

  led_matrix_row_scan_driver i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pixel_i    (pix_if),
    .result_o   (res_if)
  );

  lmrs_pkg::cfg_t    scan_cfg;
  logic [4:0]        row_ctr;
  logic              color_phase;
  lmrs_pkg::result_t scan_results_due[$];
  lmrs_pkg::result_t due;
  int unsigned src_idle_max;
  int unsigned sink_idle_max;
  int unsigned errors;
  int unsigned cycles;
  int unsigned n_pairs;
  int unsigned n_shifts;
  int unsigned n_latches;
  int unsigned n_toggles;
  int unsigned n_settings;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d transactions due", $time, scan_results_due.size());
      $display("led_matrix_row_scan_driver: mismatch");
      $finish;
    end
  end

  function automatic void predict_scan_results(input logic [7:0] upper, input logic [7:0] lower,
                                               input logic row_end);
    lmrs_pkg::result_t shift_res;
    lmrs_pkg::result_t latch_res;
    logic [4:0] addr;
    shift_res = '0;
    shift_res.kind = lmrs_pkg::KindShift;
    if (scan_cfg.two_port_mode) begin
      shift_res.port_a_data = color_phase ? {lower[3:0], lower[7:4]} : lower;
      shift_res.port_b_data = color_phase ? {upper[3:0], upper[7:4]} : upper;
    end else begin
      shift_res.port_a_data = {upper[2:0], 5'b0} | {lower[5:0], 2'b0};
    end
    shift_res.last = ~row_end;
    scan_results_due.push_back(shift_res);
    n_pairs++;
    if (row_end) begin
      addr = row_ctr;
      row_ctr = (row_ctr + 5'd1) & scan_cfg.row_mask;
      if (row_ctr == 5'd0 && scan_cfg.six_bit_color) begin
        color_phase = ~color_phase;
        n_toggles++;
      end
      latch_res = '0;
      latch_res.kind = lmrs_pkg::KindLatch;
      latch_res.row_address = addr;
      latch_res.next_interval = color_phase ? scan_cfg.interval_phase_one
                                            : scan_cfg.interval_phase_zero;
      latch_res.last = 1'b1;
      scan_results_due.push_back(latch_res);
    end
  endfunction

  task automatic compare_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i) begin
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (scan_results_due.size() == 0) begin
        errors++;
        $display("%0t: transaction with nothing due, expected none, got kind %0b", $time,
                 res_if.kind);
      end else begin
        due = scan_results_due.pop_front();
        if (due.kind == lmrs_pkg::KindLatch) n_latches++;
        else n_shifts++;
        compare_field("kind", 16'(due.kind), 16'(res_if.kind));
        compare_field("port_a_data", 16'(due.port_a_data), 16'(res_if.port_a_data));
        compare_field("port_b_data", 16'(due.port_b_data), 16'(res_if.port_b_data));
        compare_field("row_address", 16'(due.row_address), 16'(res_if.row_address));
        compare_field("next_interval", due.next_interval, res_if.next_interval);
        compare_field("last", 16'(due.last), 16'(res_if.last));
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, sink_idle_max);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
    end
  end

  task automatic send_pair(input logic [7:0] upper, input logic [7:0] lower,
                           input logic row_end);
    int unsigned gap;
    gap = $urandom_range(0, src_idle_max);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.upper_color <= upper;
    pix_if.lower_color <= lower;
    pix_if.row_end     <= row_end;
    do @(posedge clk_i); while (pix_if.ready !== 1'b1);
    predict_scan_results(upper, lower, row_end);
  endtask

  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lmrs_pkg::CfgIdxW-1:0] idx,
                           input logic [lmrs_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(input lmrs_pkg::cfg_t next_cfg);
    wait_idle();
    write_reg(lmrs_pkg::CfgTwoPortMode, lmrs_pkg::CfgDataW'(next_cfg.two_port_mode));
    write_reg(lmrs_pkg::CfgSixBitColor, lmrs_pkg::CfgDataW'(next_cfg.six_bit_color));
    write_reg(lmrs_pkg::CfgRowMask, lmrs_pkg::CfgDataW'(next_cfg.row_mask));
    write_reg(lmrs_pkg::CfgIntervalPhase0, next_cfg.interval_phase_zero);
    write_reg(lmrs_pkg::CfgIntervalPhase1, next_cfg.interval_phase_one);
    cfg_we_i <= 1'b0;
    scan_cfg = next_cfg;
    n_settings++;
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    src_idle_max  = 0;
    sink_idle_max = 0;
    send_pair(8'h00, 8'h00, 1'b0);
    send_pair(8'hff, 8'hff, 1'b0);
    send_pair(8'hff, 8'h00, 1'b0);
    send_pair(8'h00, 8'hff, 1'b0);
    send_pair(8'ha5, 8'h5a, 1'b1);
    send_pair(8'h5a, 8'ha5, 1'b1);
  endtask

  task automatic test_two_port_wrap();
    lmrs_pkg::cfg_t c;
    c = '{two_port_mode: 1'b1, six_bit_color: 1'b1, row_mask: 5'd0,
          interval_phase_zero: 16'h0000, interval_phase_one: 16'hffff};
    set_config(c);
    src_idle_max  = 6;
    sink_idle_max = 6;
    send_pair(8'h12, 8'h34, 1'b0);
    send_pair(8'hff, 8'h0f, 1'b1);
    send_pair(8'h12, 8'h34, 1'b0);
    send_pair(8'hf0, 8'h0f, 1'b1);
    send_pair(8'hab, 8'hcd, 1'b1);
  endtask

  task automatic test_phase_hold();
    lmrs_pkg::cfg_t c;
    c = '{two_port_mode: 1'b0, six_bit_color: 1'b0, row_mask: 5'd31,
          interval_phase_zero: 16'hffff, interval_phase_one: 16'h0000};
    set_config(c);
    src_idle_max  = 0;
    sink_idle_max = 6;
    send_pair(8'hff, 8'hff, 1'b0);
    repeat (3) send_pair(8'h3c, 8'hc3, 1'b1);
    c.row_mask = 5'd1;
    c.six_bit_color = 1'b1;
    c.two_port_mode = 1'b1;
    set_config(c);
    src_idle_max  = 6;
    sink_idle_max = 0;
    repeat (4) send_pair(8'h81, 8'h7e, 1'b1);
    send_pair(8'h0f, 8'hf0, 1'b0);
  endtask

  task automatic test_random_frames();
    lmrs_pkg::cfg_t c;
    int unsigned sent;
    int unsigned row_len;
    for (int unsigned p = 0; p < RandPhases; p++) begin
      c.two_port_mode = 1'($urandom_range(0, 1));
      c.six_bit_color = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: c.row_mask = 5'd0;
        1: c.row_mask = 5'd1;
        2: c.row_mask = 5'd31;
        3: c.row_mask = 5'd15;
        default: c.row_mask = 5'($urandom_range(0, 31));
      endcase
      case ($urandom_range(0, 3))
        0: c.interval_phase_zero = 16'h0000;
        1: c.interval_phase_zero = 16'hffff;
        default: c.interval_phase_zero = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: c.interval_phase_one = 16'hffff;
        1: c.interval_phase_one = 16'h0000;
        default: c.interval_phase_one = 16'($urandom);
      endcase
      set_config(c);
      src_idle_max  = (p % 4 < 2) ? 6 : 0;
      sink_idle_max = (p % 2 == 0) ? 6 : 0;
      sent = 0;
      while (sent < PhasePairs) begin
        row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        for (int unsigned k = 0; k < row_len; k++) begin
          send_pair(8'($urandom), 8'($urandom),
                    (k == row_len - 1) || ($urandom_range(0, 15) == 0));
        end
        sent += row_len;
      end
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= lmrs_pkg::CfgTwoPortMode;
    cfg_data_i         <= '0;
    pix_if.valid       <= 1'b0;
    pix_if.upper_color <= '0;
    pix_if.lower_color <= '0;
    pix_if.row_end     <= 1'b0;
    scan_cfg = '{two_port_mode: 1'b0, six_bit_color: 1'b0, row_mask: 5'd15,
                 interval_phase_zero: 16'd32, interval_phase_one: 16'd64};
    row_ctr     = '0;
    color_phase = 1'b0;
    src_idle_max  = 0;
    sink_idle_max = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_two_port_wrap();
    test_phase_hold();
    test_random_frames();
    wait_idle();

    $display("covered %0d pixel pairs: %0d shift and %0d latch transactions checked",
             n_pairs, n_shifts, n_latches);
    $display("%0d color phase toggles over %0d register settings", n_toggles, n_settings);
    if (errors == 0) begin
      $display("led_matrix_row_scan_driver: match");
    end else begin
      $display("led_matrix_row_scan_driver: mismatch");
    end
    $finish;
  end

endmodule
